FILE: rtl/mavg_pkg.sv
// Shared constants and command types for the moving-average filter.
`default_nettype none

package mavg_pkg;

    // Fixed field widths
    localparam int SAMPLE_W = 16;
    localparam int CFG_W    = 4;

    // Depth register limits and defaults
    localparam logic [CFG_W-1:0] DEPTH_MIN = 4'd4;
    localparam int MAX_TAPS_DEF = 10;

    // History line commands
    typedef enum logic [1:0] {
        HIST_HOLD,
        HIST_CLEAR,
        HIST_ROTATE,
        HIST_SHIFT
    } hist_cmd_t;

    // Shared adder operations
    typedef enum logic {
        ALU_ADD,
        ALU_SUB
    } alu_op_t;

endpackage

`default_nettype wire

FILE: rtl/mavg_alu.sv
// Shared add/subtract unit used for tap accumulation, sign handling and division steps.
`default_nettype none

module mavg_alu
    import mavg_pkg::*;
#(
    parameter int ACC_W = 20
)
(
    input  alu_op_t          op,
    input  logic [ACC_W-1:0] a,
    input  logic [ACC_W-1:0] b,
    output logic [ACC_W-1:0] y
);

    // One adder; subtract is add of the inverted operand plus one
    logic [ACC_W-1:0] b_sel;
    logic [ACC_W-1:0] cin;

    always_comb
    begin
        case (op)
            ALU_SUB:
            begin
                b_sel = ~b;
                cin   = ACC_W'(1);
            end
            default:
            begin
                b_sel = b;
                cin   = '0;
            end
        endcase
    end

    assign y = a + b_sel + cin;

endmodule

`default_nettype wire

FILE: rtl/mavg_hist.sv
// Sample history line: clear, rotate for reading through tap 0, and shift-in of new samples.
`default_nettype none

module mavg_hist
    import mavg_pkg::*;
#(
    parameter int MAX_TAPS = MAX_TAPS_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  hist_cmd_t           cmd,
    input  logic [SAMPLE_W-1:0] sample_in,
    output logic [SAMPLE_W-1:0] tap0
);

    logic [SAMPLE_W-1:0] hist_reg [MAX_TAPS];

    // Newest sample sits at index 0
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_TAPS; i++)
            begin
                hist_reg[i] <= '0;
            end
        end
        else
        begin
            unique case (cmd)
                HIST_CLEAR:
                begin
                    for (int i = 0; i < MAX_TAPS; i++)
                    begin
                        hist_reg[i] <= '0;
                    end
                end
                HIST_ROTATE:
                begin
                    // full circle after MAX_TAPS steps restores the order
                    for (int i = 0; i < MAX_TAPS - 1; i++)
                    begin
                        hist_reg[i] <= hist_reg[i+1];
                    end
                    hist_reg[MAX_TAPS-1] <= hist_reg[0];
                end
                HIST_SHIFT:
                begin
                    for (int i = 1; i < MAX_TAPS; i++)
                    begin
                        hist_reg[i] <= hist_reg[i-1];
                    end
                    hist_reg[0] <= sample_in;
                end
                default:
                begin
                end
            endcase
        end
    end

    assign tap0 = hist_reg[0];

endmodule

`default_nettype wire

FILE: rtl/moving_average_filter.sv
// Moving-average filter top level: sequencer, depth register and output register.
// Each input word yields one output word: the sum of the filter_depth newest preceding
// samples of the current series (zeros before a series start), divided by filter_depth+1
// and truncated toward zero. The accumulator is ACC_W = 16 + clog2(MAX_TAPS) bits wide.
// Each word passes the idle, accumulate, magnitude, divide and finish states: the taps are
// summed one per cycle through the rotating history line, and a restoring divide then
// produces one quotient bit per cycle, all on one shared adder. s_axis_tready is high only
// while the sequencer is idle; a finished result waits in the output register, so the
// next word can be taken while it is still pending. filter_depth accepts 4 through
// MAX_TAPS; other writes are ignored.
`default_nettype none

module moving_average_filter
    import mavg_pkg::*;
#(
    parameter int MAX_TAPS = MAX_TAPS_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    // configuration
    input  logic                cfg_we,
    input  logic [CFG_W-1:0]    cfg_wdata,     // filter_depth
    // input stream
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    input  logic [15:0]         s_axis_tdata,  // [15:0] sample
    input  logic                s_axis_tuser,  // [0] series_start
    // output stream
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    output logic [15:0]         m_axis_tdata   // [15:0] filtered
);

    localparam int ACC_W   = SAMPLE_W + $clog2(MAX_TAPS);
    localparam int DEPTH_W = $clog2(MAX_TAPS + 1);
    localparam int DIV_W   = $clog2(MAX_TAPS + 2);
    localparam int CNT_W   = $clog2((ACC_W > MAX_TAPS) ? ACC_W : MAX_TAPS);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ACCUM,
        ST_ABS,
        ST_DIV,
        ST_FINISH
    } state_t;

    state_t               state_reg, state_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic [ACC_W-1:0]     acc_reg, acc_next;
    logic [DIV_W-1:0]     rem_reg, rem_next;
    logic                 neg_reg, neg_next;
    logic [SAMPLE_W-1:0]  sample_reg, sample_next;
    logic                 out_valid_reg, out_valid_next;
    logic [SAMPLE_W-1:0]  out_data_reg, out_data_next;
    logic [DEPTH_W-1:0]   depth_reg, depth_next;

    hist_cmd_t            hist_cmd;
    logic [SAMPLE_W-1:0]  tap0;
    alu_op_t              alu_op;
    logic [ACC_W-1:0]     alu_a, alu_b, alu_y;

    logic                 in_fire;
    logic [DIV_W-1:0]     divisor;
    logic                 no_borrow;
    logic                 tap_used;

    mavg_hist #(
        .MAX_TAPS (MAX_TAPS)
    ) u_hist (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (hist_cmd),
        .sample_in (sample_reg),
        .tap0      (tap0)
    );

    mavg_alu #(
        .ACC_W (ACC_W)
    ) u_alu (
        .op (alu_op),
        .a  (alu_a),
        .b  (alu_b),
        .y  (alu_y)
    );

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    assign divisor   = DIV_W'(depth_reg) + DIV_W'(1);
    assign tap_used  = (32'(cnt_reg) < 32'(depth_reg));
    assign no_borrow = !alu_y[ACC_W-1];

    // Depth register: only in-range writes take effect
    always_comb
    begin
        depth_next = depth_reg;
        if (cfg_we && (cfg_wdata >= DEPTH_MIN) && (32'(cfg_wdata) <= MAX_TAPS))
        begin
            depth_next = DEPTH_W'(cfg_wdata);
        end
    end

    // Sequencer and datapath next-state
    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        acc_next       = acc_reg;
        rem_next       = rem_reg;
        neg_next       = neg_reg;
        sample_next    = sample_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        hist_cmd       = HIST_HOLD;
        alu_op         = ALU_ADD;
        alu_a          = acc_reg;
        alu_b          = '0;

        // output word taken
        if (out_valid_reg && m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    sample_next = s_axis_tdata;
                    acc_next    = '0;
                    cnt_next    = '0;
                    if (s_axis_tuser)
                    begin
                        hist_cmd = HIST_CLEAR;
                    end
                    state_next = ST_ACCUM;
                end
            end
            ST_ACCUM:
            begin
                // add the tap at the head, then rotate the next one in
                alu_op   = ALU_ADD;
                alu_a    = acc_reg;
                alu_b    = tap_used ? {{(ACC_W-SAMPLE_W){tap0[SAMPLE_W-1]}}, tap0} : '0;
                acc_next = alu_y;
                hist_cmd = HIST_ROTATE;
                cnt_next = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(MAX_TAPS - 1))
                begin
                    state_next = ST_ABS;
                end
            end
            ST_ABS:
            begin
                // take the magnitude of the sum; history is restored, push the sample
                alu_op   = ALU_SUB;
                alu_a    = '0;
                alu_b    = acc_reg;
                neg_next = acc_reg[ACC_W-1];
                if (acc_reg[ACC_W-1])
                begin
                    acc_next = alu_y;
                end
                hist_cmd   = HIST_SHIFT;
                rem_next   = '0;
                cnt_next   = '0;
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                // restoring divide, one quotient bit per cycle into acc LSB
                alu_op = ALU_SUB;
                alu_a  = ACC_W'({rem_reg, acc_reg[ACC_W-1]});
                alu_b  = ACC_W'(divisor);
                if (no_borrow)
                begin
                    rem_next = alu_y[DIV_W-1:0];
                end
                else
                begin
                    rem_next = {rem_reg[DIV_W-2:0], acc_reg[ACC_W-1]};
                end
                acc_next = {acc_reg[ACC_W-2:0], no_borrow};
                cnt_next = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(ACC_W - 1))
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                // restore the sign and load the output register once it is free
                alu_op = ALU_SUB;
                alu_a  = '0;
                alu_b  = acc_reg;
                if (!out_valid_reg || m_axis_tready)
                begin
                    out_data_next  = neg_reg ? alu_y[SAMPLE_W-1:0] : acc_reg[SAMPLE_W-1:0];
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
            depth_reg     <= DEPTH_W'(MAX_TAPS);
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
            depth_reg     <= depth_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        acc_reg      <= acc_next;
        rem_reg      <= rem_next;
        neg_reg      <= neg_next;
        sample_reg   <= sample_next;
        out_data_reg <= out_data_next;
    end

endmodule

`default_nettype wire

FILE: dv/moving_average_filter_tb.sv
// Self-checking testbench for the moving-average filter: directed and random sample streams.
module moving_average_filter_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import mavg_pkg::*;

    // Depth settings for the first phases: extremes, mid values and ignored writes
    localparam logic [CFG_W-1:0] DEPTH_PLAN [11] = '{4'd4, 4'd3, 4'd10, 4'd0, 4'd7, 4'd15,
                                                     4'd5, 4'd11, 4'd9, 4'd6, 4'd8};
    localparam int PHASES      = 14;
    localparam int PHASE_WORDS = 130;

    // Running average predictor plus the queue of averages still owed by the block
    class average_scoreboard;
        logic signed [SAMPLE_W-1:0] history [MAX_TAPS_DEF];
        logic [CFG_W-1:0]           depth;
        logic signed [SAMPLE_W-1:0] pending_averages [$];
        int                         mismatches;
        int                         words_in;
        int                         series_count;
        int                         ignored_writes;
        logic [15:0]                depths_seen;

        function new();
            foreach (history[i])
                history[i] = '0;
            depth          = CFG_W'(MAX_TAPS_DEF);
            mismatches     = 0;
            words_in       = 0;
            series_count   = 0;
            ignored_writes = 0;
            depths_seen    = '0;
        endfunction

        // Out-of-range depth values leave the register as it was
        function void write_depth(logic [CFG_W-1:0] value);
            if (value >= DEPTH_MIN && value <= CFG_W'(MAX_TAPS_DEF))
                depth = value;
            else
                ignored_writes++;
        endfunction

        function int pending();
            return pending_averages.size();
        endfunction

        // Average of the preceding samples, then shift the new one in
        function void note_sample(logic signed [SAMPLE_W-1:0] smp, logic start);
            int acc;
            int divisor;
            acc     = 0;
            divisor = int'(depth) + 1;
            if (start)
            begin
                foreach (history[i])
                    history[i] = '0;
                series_count++;
            end
            for (int i = 0; i < int'(depth); i++)
                acc += history[i];
            pending_averages.push_back(SAMPLE_W'(acc / divisor));
            for (int i = MAX_TAPS_DEF - 1; i > 0; i--)
                history[i] = history[i - 1];
            history[0] = smp;
            depths_seen[depth] = 1'b1;
            words_in++;
        endfunction

        task report(string msg);
            $display("MISMATCH at %0t ns: %s", $time, msg);
            mismatches++;
        endtask

        task check_average(logic [SAMPLE_W-1:0] got);
            logic signed [SAMPLE_W-1:0] want;
            if (pending_averages.size() == 0)
            begin
                report($sformatf("output word %0d with no sample waiting", $signed(got)));
            end
            else
            begin
                want = pending_averages.pop_front();
                if (got !== want)
                    report($sformatf("filtered %0d, predicted %0d", $signed(got), want));
            end
        endtask
    endclass

    logic                clk           = 1'b0;
    logic                rst_n         = 1'b0;
    logic                cfg_we        = 1'b0;
    logic [CFG_W-1:0]    cfg_wdata     = '0;
    logic                s_axis_tvalid = 1'b0;
    logic                s_axis_tready;
    logic [15:0]         s_axis_tdata  = '0;   // [15:0] sample
    logic                s_axis_tuser  = 1'b0; // [0] series_start
    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    logic [15:0]         m_axis_tdata;         // [15:0] filtered
    bit                  no_idle       = 1'b0;

    average_scoreboard sb = new();

    moving_average_filter u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // 10 ns clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Output side stalls about a third of the time
    always @(negedge clk)
    begin
        m_axis_tready <= no_idle || ($urandom_range(99) >= 35);
    end

    // Check every accepted output word
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_average(m_axis_tdata);
    end

    // Present one word, with random gaps ahead of it; returns at the next falling edge
    task automatic send_word(input logic [15:0] smp, input logic start);
        while (!no_idle && $urandom_range(99) < 35)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= smp;
        s_axis_tuser  <= start;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        sb.note_sample(smp, start);
        @(negedge clk);
    endtask

    // Hold the input quiet until every predicted average has come out
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (sb.pending() != 0)
            @(negedge clk);
    endtask

    task automatic program_depth(input logic [CFG_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        sb.write_depth(value);
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // Stimulus
    initial
    begin
        logic [15:0] smp;
        logic        start;
        int          pick;

        repeat (4) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Full-scale positive and negative runs at the reset depth, then small values
        for (int i = 0; i < 11; i++)
            send_word(16'h7fff, i == 0);
        for (int i = 0; i < 11; i++)
            send_word(16'h8000, i == 0);
        send_word(16'hffff, 1'b0);
        send_word(16'h0001, 1'b0);
        send_word(16'h0000, 1'b1);

        // Random phases, each opened by its own depth write (out-of-range values are ignored)
        for (int ph = 0; ph < PHASES; ph++)
        begin
            wait_drained();
            program_depth(ph < 11 ? DEPTH_PLAN[ph] : CFG_W'($urandom_range(15)));
            no_idle <= (ph == 6);
            for (int n = 0; n < PHASE_WORDS; n++)
            begin
                pick = $urandom_range(99);
                if (pick < 10)
                    smp = $urandom_range(1) ? 16'h7fff : 16'h8000;
                else if (pick < 20)
                    smp = 16'($urandom_range(8)) - 16'd4;
                else
                    smp = 16'($urandom);
                start = ($urandom_range(15) == 0);
                send_word(smp, start);
            end
        end

        wait_drained();
        repeat (60) @(negedge clk);

        $display("Covered %0d words in %0d series; depths used (10 down to 4): %b",
                 sb.words_in, sb.series_count, sb.depths_seen[10:4]);
        $display("Out-of-range depth writes ignored: %0d; mismatches: %0d",
                 sb.ignored_writes, sb.mismatches);
        if (sb.mismatches == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    // Watchdog
    initial
    begin
        #5_000_000;
        $display("Timeout with %0d averages still outstanding", sb.pending());
        $display("Some tests failed");
        $finish;
    end
endmodule
